/* rtl/core/svpwm_pkg.sv */
// ---------------------------------------------------------------------------
// svpwm_pkg: shared types and constants for the SVPWM compare core
// Holds the fixed-point constants, field widths, register indexes and the
// structs that pass between the front end, the queue and the back end.
// ---------------------------------------------------------------------------
package svpwm_pkg;

  localparam int VoltW  = 16;
  localparam int CountW = 16;
  localparam int NW     = 35;   // |vector term| < 2^34
  localparam int ProdW  = NW + CountW;
  localparam int DenW   = 36;   // max of bus<<16 and n1+n2

  localparam logic [17:0] QSqrt3     = 18'd113512;
  localparam logic [16:0] QHalfSqrt3 = 17'd56756;
  localparam logic [16:0] QThreeHalf = 17'd98304;

  localparam logic [0:0] RegPeriod = 1'b0;
  localparam logic [0:0] RegBus    = 1'b1;

  localparam logic [CountW-1:0] PeriodReset = 16'd8000;
  localparam logic [CountW-1:0] BusReset    = 16'd6144;

  // Front end result: sector code and the two active terms, already clipped.
  typedef struct packed {
    logic [2:0]    code;
    logic [NW-1:0] n1;
    logic [NW-1:0] n2;
  } svpwm_job_t;

  localparam int JobW = $bits(svpwm_job_t);

endpackage

/* rtl/core/svpwm_front.sv */
// ---------------------------------------------------------------------------
// svpwm_front: sector classification and active-vector terms
// Three exact sign tests give the code; X, Y, Z products are registered, then
// the code picks the two active terms. Two-stage pipeline with valid/stall.
// ---------------------------------------------------------------------------
module svpwm_front import svpwm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [VoltW-1:0]  alpha_voltage,
  input  logic signed [VoltW-1:0]  beta_voltage,
  output logic                     job_valid,
  input  logic                     job_stall,
  output svpwm_job_t               job
);

  logic                 s1_valid;
  logic [2:0]           s1_code;
  logic signed [NW:0]   s1_x;
  logic signed [NW:0]   s1_y;
  logic signed [NW:0]   s1_z;
  logic                 s1_adv;
  logic                 s2_adv;
  logic                 a_bit;
  logic                 b_bit;
  logic                 c_bit;
  logic signed [33:0]   a3sq;
  logic signed [33:0]   bsq;
  logic                 mag_a;
  logic signed [NW:0]   sel1;
  logic signed [NW:0]   sel2;
  logic signed [NW:0]   fa;
  logic signed [NW:0]   hb;

  // 3*a^2 > b^2 decides the mixed-sign cases exactly
  always_comb begin
    a3sq  = 34'(alpha_voltage * alpha_voltage) * 34'sd3;
    bsq   = 34'(beta_voltage * beta_voltage);
    mag_a = a3sq > bsq;
    a_bit = beta_voltage > 0;
    // c: sqrt3*a + b < 0
    if (alpha_voltage == 0) begin
      c_bit = beta_voltage < 0;
    end else if (beta_voltage == 0 || ((alpha_voltage > 0) == (beta_voltage > 0))) begin
      c_bit = alpha_voltage < 0;
    end else begin
      c_bit = mag_a ? (alpha_voltage < 0) : (beta_voltage < 0);
    end
    // b: sqrt3*a - b > 0
    if (alpha_voltage == 0) begin
      b_bit = beta_voltage < 0;
    end else if (beta_voltage == 0 || ((alpha_voltage > 0) == (beta_voltage < 0))) begin
      b_bit = alpha_voltage > 0;
    end else begin
      b_bit = mag_a ? (alpha_voltage > 0) : (beta_voltage < 0);
    end
  end

  assign s2_adv   = !job_valid || !job_stall;
  assign s1_adv   = !s1_valid || s2_adv;
  assign in_stall = !s1_adv;

  assign fa = (NW+1)'($signed({1'b0, QThreeHalf}) * alpha_voltage);
  assign hb = (NW+1)'($signed({1'b0, QHalfSqrt3}) * beta_voltage);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= in_valid;
    end
    if (s1_adv && in_valid) begin
      s1_code <= {c_bit, b_bit, a_bit};
      s1_x    <= (NW+1)'($signed({1'b0, QSqrt3}) * beta_voltage);
      s1_y    <= fa + hb;
      s1_z    <= hb - fa;
    end
  end

  always_comb begin
    unique case (s1_code)
      3'd1:    begin sel1 = s1_z;  sel2 = s1_y;  end
      3'd2:    begin sel1 = s1_y;  sel2 = -s1_x; end
      3'd3:    begin sel1 = -s1_z; sel2 = s1_x;  end
      3'd4:    begin sel1 = -s1_x; sel2 = s1_z;  end
      3'd5:    begin sel1 = s1_x;  sel2 = -s1_y; end
      default: begin sel1 = -s1_y; sel2 = -s1_z; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (s2_adv) begin
      job_valid <= s1_valid;
    end
    if (s2_adv && s1_valid) begin
      job.code <= s1_code;
      job.n1   <= sel1[NW] ? '0 : sel1[NW-1:0];
      job.n2   <= sel2[NW] ? '0 : sel2[NW-1:0];
    end
  end

endmodule

/* rtl/core/svpwm_fifo.sv */
// ---------------------------------------------------------------------------
// svpwm_fifo: short job queue between front and back end
// Four entries, registered flags; full raises stall to the front end.
// ---------------------------------------------------------------------------
module svpwm_fifo import svpwm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_valid,
  output logic        wr_stall,
  input  svpwm_job_t  wr_data,
  output logic        rd_valid,
  input  logic        rd_take,
  output svpwm_job_t  rd_data
);

  svpwm_job_t  mem [4];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;
  logic [2:0]  count;
  logic        push;
  logic        pop;

  assign wr_stall = count == 3'd4;
  assign rd_valid = count != 3'd0;
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_take && rd_valid;
  assign rd_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
    if (push) mem[wr_ptr] <= wr_data;
  end

endmodule

/* rtl/core/svpwm_div.sv */
// ---------------------------------------------------------------------------
// svpwm_div: radix-2 restoring divider
// One quotient bit per cycle, for all ProdW bits of the quotient.
// ---------------------------------------------------------------------------
module svpwm_div import svpwm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ProdW-1:0]  dividend,
  input  logic [DenW-1:0]   divisor,
  output logic              busy,
  output logic              done,
  output logic [ProdW-1:0]  quotient
);

  localparam int CntW = $clog2(ProdW + 1);

  logic [DenW:0]      rem;
  logic [DenW-1:0]    dsr;
  logic [CntW-1:0]    cnt;
  logic [DenW:0]      shifted;
  logic [DenW:0]      diff;

  assign shifted = {rem[DenW-1:0], quotient[ProdW-1]};
  assign diff    = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CntW'(ProdW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
    if (start) begin
      rem      <= '0;
      dsr      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      if (!diff[DenW]) begin
        rem      <= diff;
        quotient <= {quotient[ProdW-2:0], 1'b1};
      end else begin
        rem      <= shifted;
        quotient <= {quotient[ProdW-2:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/core/svpwm_back.sv */
// ---------------------------------------------------------------------------
// svpwm_back: active times, overmodulation rescale and compare values
// A sequencer drives one shared divider: t1, t2 by bus<<16, and if the sum
// exceeds the period, again by n1+n2. Result sits in an output register.
// ---------------------------------------------------------------------------
module svpwm_back import svpwm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [CountW-1:0]  period,
  input  logic [CountW-1:0]  bus,
  input  logic               job_valid,
  output logic               job_take,
  input  svpwm_job_t         job,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         sector_code,
  output logic [CountW-1:0]  compare_a,
  output logic [CountW-1:0]  compare_b,
  output logic [CountW-1:0]  compare_c,
  output logic               overmodulated
);

  typedef enum logic [2:0] {
    IDLE, MUL1, DIV1, DIV2, CHECK, DIV3, DIV4, FINISH
  } state_t;

  state_t              state;
  svpwm_job_t          cur;
  logic [CountW-1:0]   p;
  logic [DenW-1:0]     den;
  logic [ProdW-1:0]    prod1;
  logic [ProdW-1:0]    prod2;
  logic [ProdW-1:0]    t1;
  logic [ProdW-1:0]    t2;
  logic                flag;
  logic                div_start;
  logic [ProdW-1:0]    div_dividend;
  logic [DenW-1:0]     div_divisor;
  logic                div_busy;
  logic                div_done;
  logic [ProdW-1:0]    div_q;
  logic [ProdW:0]      tsum;
  logic [CountW+1:0]   t0;
  logic [ProdW:0]      lo;
  logic [ProdW:0]      mid;
  logic [ProdW:0]      hi;
  logic [CountW-1:0]   lo_c;
  logic [CountW-1:0]   mid_c;
  logic [CountW-1:0]   hi_c;
  logic                out_free;

  svpwm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign out_free = !out_valid || !out_stall;
  assign job_take = state == IDLE && job_valid;
  assign tsum     = {1'b0, t1} + {1'b0, t2};

  always_comb begin
    t0 = '0;
    if (tsum <= (ProdW+1)'(p)) begin
      t0 = (CountW+2)'(((ProdW+1)'(p) - tsum) >> 2);
    end
    lo    = (ProdW+1)'(t0);
    mid   = (ProdW+1)'(t1 >> 1) + lo;
    hi    = (ProdW+1)'(t2 >> 1) + mid;
    lo_c  = (lo  > (ProdW+1)'(p)) ? p : lo[CountW-1:0];
    mid_c = (mid > (ProdW+1)'(p)) ? p : mid[CountW-1:0];
    hi_c  = (hi  > (ProdW+1)'(p)) ? p : hi[CountW-1:0];
  end

  always_comb begin
    div_start    = 1'b0;
    div_dividend = prod1;
    div_divisor  = den;
    unique case (state)
      MUL1:    div_start = 1'b1;
      DIV1:    begin div_start = div_done; div_dividend = prod2; end
      CHECK:   begin
        div_start   = tsum > (ProdW+1)'(p);
        div_divisor = DenW'(cur.n1) + DenW'(cur.n2);
      end
      DIV3:    begin
        div_start    = div_done;
        div_dividend = prod2;
        div_divisor  = DenW'(cur.n1) + DenW'(cur.n2);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != FINISH) out_valid <= 1'b0;
      unique case (state)
        IDLE: begin
          if (job_valid) begin
            cur   <= job;
            p     <= period;
            den   <= DenW'({(bus == '0) ? CountW'(1) : bus, 16'd0});
            // one registered multiplier pass per item
            prod1 <= ProdW'(job.n1 * period);
            prod2 <= ProdW'(job.n2 * period);
            state <= MUL1;
          end
        end
        MUL1: begin
          state <= DIV1;
        end
        DIV1: if (div_done) begin
          t1    <= div_q;
          state <= DIV2;
        end
        DIV2: if (div_done) begin
          t2    <= div_q;
          state <= CHECK;
        end
        CHECK: begin
          flag  <= tsum > (ProdW+1)'(p);
          state <= (tsum > (ProdW+1)'(p)) ? DIV3 : FINISH;
        end
        DIV3: if (div_done) begin
          t1    <= div_q;
          state <= DIV4;
        end
        DIV4: if (div_done) begin
          t2    <= div_q;
          state <= FINISH;
        end
        FINISH: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            sector_code   <= cur.code;
            overmodulated <= flag;
            unique case (cur.code)
              3'd1: begin compare_a <= mid_c; compare_b <= lo_c;  compare_c <= hi_c;  end
              3'd2: begin compare_a <= lo_c;  compare_b <= hi_c;  compare_c <= mid_c; end
              3'd3: begin compare_a <= lo_c;  compare_b <= mid_c; compare_c <= hi_c;  end
              3'd4: begin compare_a <= hi_c;  compare_b <= mid_c; compare_c <= lo_c;  end
              3'd5: begin compare_a <= hi_c;  compare_b <= lo_c;  compare_c <= mid_c; end
              default: begin compare_a <= mid_c; compare_b <= hi_c; compare_c <= lo_c; end
            endcase
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
    if (state == IDLE && job_valid) flag <= 1'b0;
  end

endmodule

/* rtl/core/svpwm_sector_compare_core.sv */
// ---------------------------------------------------------------------------
// svpwm_sector_compare_core: seven-segment SVPWM compare generator
// Turns an (alpha, beta) voltage vector into sector code and three
// centre-aligned compare values.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid/in_stall with alpha_voltage, beta_voltage.
//   Output channel: out_valid/out_stall with sector_code, compare_a/b/c and
//   overmodulated. Config channel: cfg_valid/cfg_ready, cfg_index, cfg_data;
//   index 0 is period_count, index 1 is bus_voltage, other indexes ignored.
//   Front end classifies a vector in its s1 and job registers and posts it to a
//   4-deep queue; the back end takes one item at a time and runs two divisions
//   on it (four when the vector is overmodulated) on the bit-serial divider that
//   serves all four divisions. The front end keeps accepting while the back end
//   works until the queue fills.
//   Reset: period 8000, bus 6144, queue and output empty.
//   Receiver stall holds the result in the output register; the back end
//   waits, then the queue and finally in_stall back up.
// ---------------------------------------------------------------------------
module svpwm_sector_compare_core import svpwm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [VoltW-1:0]  alpha_voltage,
  input  logic signed [VoltW-1:0]  beta_voltage,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [2:0]               sector_code,
  output logic [CountW-1:0]        compare_a,
  output logic [CountW-1:0]        compare_b,
  output logic [CountW-1:0]        compare_c,
  output logic                     overmodulated,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [0:0]               cfg_index,
  input  logic [15:0]              cfg_data
);

  logic [CountW-1:0] period_count;
  logic [CountW-1:0] bus_voltage;
  logic              fj_valid;
  logic              fj_stall;
  svpwm_job_t        fj;
  logic              q_valid;
  logic              q_take;
  svpwm_job_t        q_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_count <= PeriodReset;
      bus_voltage  <= BusReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegPeriod: period_count <= cfg_data;
        RegBus:    bus_voltage  <= cfg_data;
        default:   ;
      endcase
    end
  end

  svpwm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .alpha_voltage (alpha_voltage),
    .beta_voltage  (beta_voltage),
    .job_valid     (fj_valid),
    .job_stall     (fj_stall),
    .job           (fj)
  );

  svpwm_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fj_valid),
    .wr_stall (fj_stall),
    .wr_data  (fj),
    .rd_valid (q_valid),
    .rd_take  (q_take),
    .rd_data  (q_job)
  );

  svpwm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .period        (period_count),
    .bus           (bus_voltage),
    .job_valid     (q_valid),
    .job_take      (q_take),
    .job           (q_job),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sector_code   (sector_code),
    .compare_a     (compare_a),
    .compare_b     (compare_b),
    .compare_c     (compare_c),
    .overmodulated (overmodulated)
  );

endmodule

/* rtl/core/svpwm_checker.sv */
// ---------------------------------------------------------------------------
// svpwm_checker: port-level checks for the SVPWM compare core
// Watches the top-level ports and flags results that break the contract.
// ---------------------------------------------------------------------------
module svpwm_checker import svpwm_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [2:0]         sector_code,
  input logic [CountW-1:0]  compare_a,
  input logic [CountW-1:0]  compare_b,
  input logic [CountW-1:0]  compare_c
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(compare_a))
    else $error("stalled result changed");

  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sector_code != 3'd7)
    else $error("sector code 7");

  // in sector one phase A is middle, B lowest
  a_order1: assert property (@(posedge clk) disable iff (rst)
    out_valid && sector_code == 3'd1 |-> compare_b <= compare_a && compare_a <= compare_c)
    else $error("sector 1 compare order");

  a_order4: assert property (@(posedge clk) disable iff (rst)
    out_valid && sector_code == 3'd4 |-> compare_c <= compare_b && compare_b <= compare_a)
    else $error("sector 4 compare order");

endmodule

bind svpwm_sector_compare_core svpwm_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .sector_code (sector_code),
  .compare_a   (compare_a),
  .compare_b   (compare_b),
  .compare_c   (compare_c)
);
